// ----- design/pidwg_pkg.sv -----
// Shared widths, register indexes and command codes of the PID controller.
package pidwg_pkg;

	localparam int DW      = 32;          // data word
	localparam int ERR_W   = DW + 1;      // exact difference of two data words
	localparam int GDK_W   = 46;          // |gain_d| * 10000
	localparam int AACC_W  = ERR_W + DW;  // product accumulator, 33 x 32
	localparam int DACC_W  = ERR_W + GDK_W;
	localparam int QB      = 51;          // quotient bits per division
	localparam int TOP_W   = DACC_W - QB;
	localparam int MUL_STEPS = ERR_W;
	localparam int CNT_W   = 6;
	localparam int IW      = 48;          // integral working width
	localparam int SUM_W   = 68;

	localparam logic [DW-1:0] USEC_PER_SEC = 32'd1000000;
	localparam logic [13:0]   D_SCALE      = 14'd10000;

	typedef enum logic [1:0] {
		CFG_GAIN_P,
		CFG_GAIN_I,
		CFG_GAIN_D,
		CFG_WINDUP
	} cfg_idx_t;

	typedef enum logic {
		CMD_UPDATE,
		CMD_CLEAR
	} cmd_t;

endpackage

// ----- design/pidwg_in_if.sv -----
// Input channel of the PID controller: valid/ready with update or clear item.
interface pidwg_in_if import pidwg_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 cmd;
	logic signed [DW-1:0] target;
	logic signed [DW-1:0] measured;
	logic [DW-1:0]        now_us;

	modport source(output valid, cmd, target, measured, now_us, input ready);
	modport sink(input valid, cmd, target, measured, now_us, output ready);
endinterface

// ----- design/pidwg_out_if.sv -----
// Output channel of the PID controller: valid/ready with the drive value.
interface pidwg_out_if import pidwg_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] drive;

	modport source(output valid, drive, input ready);
	modport sink(input valid, drive, output ready);
endinterface

// ----- design/pid_with_windup_guard_top.sv -----
// PID controller with integral clamp, bit-serial multipliers and dividers.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-------------------------------------
//  in_ch    | in  | valid / ready  | cmd, target, measured, now_us
//  out_ch   | out | valid / ready  | drive
//  cfg      | in  | cfg_we         | cfg_idx, cfg_data
//
// Update item, from transfer to result in the output register:
// 33 shift-add steps (error*dt, gain_p*error, gain_d*10000*delta), one load,
// 51 restoring division steps (by 1e6 and by dt, one quotient bit each),
// one integral clamp, 33 shift-add steps for gain_i*integral, one final sum.
// Reset clears gains, limit and state, no sweep.
// The result waits in the output register; the next item is taken meanwhile.
module pid_with_windup_guard_top import pidwg_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_idx,
	input  logic [DW-1:0] cfg_data,
	pidwg_in_if.sink      in_ch,
	pidwg_out_if.source   out_ch
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DLOAD,
		ST_DIV,
		ST_INTEG,
		ST_MULI,
		ST_SUM
	} state_t;

	function automatic logic [DW-1:0] mag_dw(input logic [DW-1:0] v);
		mag_dw = v[DW-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [ERR_W-1:0] mag_err(input logic [ERR_W-1:0] v);
		mag_err = v[ERR_W-1] ? (~v + 1'b1) : v;
	endfunction

	// one restoring step: {quotient bit, next remainder}
	function automatic logic [DW:0] div_step(input logic [DW-1:0] r, input logic nb,
		input logic [DW-1:0] d);
		logic [DW:0] t;
		t = {r, nb};
		if (t >= {1'b0, d})
			div_step = {1'b1, DW'(t - {1'b0, d})};
		else
			div_step = {1'b0, t[DW-1:0]};
	endfunction

	// configuration
	logic signed [DW-1:0] gain_p_q, gain_i_q;
	logic                 gd_neg_q;
	logic [GDK_W-1:0]     gd_k_q;
	logic [DW-2:0]        windup_q;

	// architectural state
	logic [DW-1:0]        prev_time_q;
	logic signed [DW-1:0] integral_q, prev_meas_q;

	// control
	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q;
	logic signed [DW-1:0] drive_q;

	// datapath
	logic [DW-1:0]        dt_q;
	logic                 dt_zero_q, e_neg_q, p_neg_q, d_neg_q, i_neg_q;
	logic [ERR_W-1:0]     mr_e_q, mr_d_q;
	logic [AACC_W-1:0]    a_acc_q, p_acc_q;
	logic [DACC_W-1:0]    d_acc_q;
	logic [QB-1:0]        n1_q, n2_q;
	logic [DW-1:0]        r1_q, r2_q;
	logic                 ovf_q;

	logic [DW-1:0]        gd_mag, gp_mag, gi_mag, mcand_a, dt_w;
	logic [ERR_W-1:0]     err_w, diff_w;
	logic                 in_xfer, upd_xfer, clr_xfer, sum_load;
	logic [DACC_W-1:0]    d_shift;
	logic [TOP_W-1:0]     top2;
	logic [DW:0]          st1, st2;
	logic signed [IW-1:0] i_ext, inc_ext, i_sum, lim_pos, lim_neg;
	logic signed [DW-1:0] i_new;
	logic signed [AACC_W:0] p_sgn, i_sgn, pterm, iterm;
	logic [QB-1:0]        dmag;
	logic signed [QB+1:0] dterm;
	logic signed [SUM_W-1:0] sum_w;
	logic signed [DW-1:0] sat_w;

	assign gd_mag  = mag_dw(cfg_data);
	assign gp_mag  = mag_dw(gain_p_q);
	assign gi_mag  = mag_dw(gain_i_q);
	assign mcand_a = (state_q == ST_MULI) ? gi_mag : dt_q;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign upd_xfer = in_xfer && (in_ch.cmd == CMD_UPDATE);
	assign clr_xfer = in_xfer && (in_ch.cmd == CMD_CLEAR);

	assign err_w  = {in_ch.target[DW-1], in_ch.target}
		- {in_ch.measured[DW-1], in_ch.measured};
	assign diff_w = {in_ch.measured[DW-1], in_ch.measured}
		- {prev_meas_q[DW-1], prev_meas_q};
	assign dt_w   = in_ch.now_us - prev_time_q;

	assign d_shift = d_acc_q >> FRAC_BITS;
	assign top2    = d_shift[DACC_W-1:QB];
	assign st1     = div_step(r1_q, n1_q[QB-1], USEC_PER_SEC);
	assign st2     = div_step(r2_q, n2_q[QB-1], dt_q);

	// integral step and clamp
	always_comb begin
		i_ext   = IW'(integral_q);
		inc_ext = signed'(IW'(n1_q));
		i_sum   = e_neg_q ? (i_ext - inc_ext) : (i_ext + inc_ext);
		lim_pos = signed'(IW'(windup_q));
		lim_neg = -lim_pos;
		if (i_sum > lim_pos)
			i_new = DW'(lim_pos);
		else if (i_sum < lim_neg)
			i_new = DW'(lim_neg);
		else
			i_new = DW'(i_sum);
	end

	// final sum and saturation
	always_comb begin
		p_sgn = p_neg_q ? -signed'({1'b0, p_acc_q}) : signed'({1'b0, p_acc_q});
		i_sgn = i_neg_q ? -signed'({1'b0, a_acc_q}) : signed'({1'b0, a_acc_q});
		pterm = p_sgn >>> FRAC_BITS;
		iterm = i_sgn >>> FRAC_BITS;
		dmag  = ovf_q ? '1 : n2_q;
		if (dt_zero_q)
			dterm = '0;
		else if (d_neg_q)
			dterm = -signed'({2'b00, dmag});
		else
			dterm = signed'({2'b00, dmag});
		sum_w = SUM_W'(pterm) + SUM_W'(iterm) + SUM_W'(dterm);
		if (sum_w[SUM_W-1:DW-1] == '0 || sum_w[SUM_W-1:DW-1] == '1)
			sat_w = DW'(sum_w);
		else if (sum_w[SUM_W-1])
			sat_w = signed'({1'b1, {(DW-1){1'b0}}});
		else
			sat_w = signed'({1'b0, {(DW-1){1'b1}}});
	end

	assign sum_load = (state_q == ST_SUM) && (!out_valid_q || out_ch.ready);

	assign out_ch.valid = out_valid_q;
	assign out_ch.drive = drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gd_neg_q <= 1'b0;
			gd_k_q   <= '0;
			windup_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_GAIN_P: gain_p_q <= cfg_data;
				CFG_GAIN_I: gain_i_q <= cfg_data;
				CFG_GAIN_D: begin
					gd_neg_q <= cfg_data[DW-1];
					gd_k_q   <= GDK_W'({{(GDK_W-DW){1'b0}}, gd_mag}
						* {{(GDK_W-14){1'b0}}, D_SCALE});
				end
				CFG_WINDUP: windup_q <= cfg_data[DW-2:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			drive_q     <= '0;
			prev_time_q <= '0;
			integral_q  <= '0;
			prev_meas_q <= '0;
		end else begin
			if (sum_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (clr_xfer) begin
						integral_q  <= '0;
						prev_time_q <= in_ch.now_us;
					end else if (upd_xfer) begin
						prev_time_q <= in_ch.now_us;
						prev_meas_q <= in_ch.measured;
						cnt_q       <= CNT_W'(MUL_STEPS - 1);
						state_q     <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (cnt_q == '0)
						state_q <= ST_DLOAD;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_DLOAD: begin
					cnt_q   <= CNT_W'(QB - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0)
						state_q <= ST_INTEG;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_INTEG: begin
					integral_q <= i_new;
					cnt_q      <= CNT_W'(MUL_STEPS - 1);
					state_q    <= ST_MULI;
				end
				ST_MULI: begin
					if (cnt_q == '0)
						state_q <= ST_SUM;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_SUM: begin
					// hold until the previous result has been taken
					if (sum_load) begin
						drive_q <= sat_w;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (upd_xfer) begin
					dt_q      <= dt_w;
					dt_zero_q <= (dt_w == '0);
					e_neg_q   <= err_w[ERR_W-1];
					p_neg_q   <= err_w[ERR_W-1] ^ gain_p_q[DW-1];
					d_neg_q   <= diff_w[ERR_W-1] ^ gd_neg_q;
					mr_e_q    <= mag_err(err_w);
					mr_d_q    <= mag_err(diff_w);
					a_acc_q   <= '0;
					p_acc_q   <= '0;
					d_acc_q   <= '0;
				end
			end
			ST_MUL: begin
				a_acc_q <= {a_acc_q[AACC_W-2:0], 1'b0}
					+ (mr_e_q[ERR_W-1] ? AACC_W'(mcand_a) : '0);
				p_acc_q <= {p_acc_q[AACC_W-2:0], 1'b0}
					+ (mr_e_q[ERR_W-1] ? AACC_W'(gp_mag) : '0);
				d_acc_q <= {d_acc_q[DACC_W-2:0], 1'b0}
					+ (mr_d_q[ERR_W-1] ? DACC_W'(gd_k_q) : '0);
				mr_e_q  <= {mr_e_q[ERR_W-2:0], 1'b0};
				mr_d_q  <= {mr_d_q[ERR_W-2:0], 1'b0};
			end
			ST_DLOAD: begin
				n1_q  <= a_acc_q[QB-1:0];
				r1_q  <= DW'(a_acc_q[AACC_W-1:QB]);
				n2_q  <= d_shift[QB-1:0];
				r2_q  <= DW'(top2);
				// quotient too wide for the register: drive saturates anyway
				ovf_q <= (DW'(top2) >= dt_q);
			end
			ST_DIV: begin
				n1_q <= {n1_q[QB-2:0], st1[DW]};
				r1_q <= st1[DW-1:0];
				n2_q <= {n2_q[QB-2:0], st2[DW]};
				r2_q <= st2[DW-1:0];
			end
			ST_INTEG: begin
				mr_e_q  <= {1'b0, mag_dw(i_new)};
				i_neg_q <= i_new[DW-1] ^ gain_i_q[DW-1];
				a_acc_q <= '0;
			end
			ST_MULI: begin
				a_acc_q <= {a_acc_q[AACC_W-2:0], 1'b0}
					+ (mr_e_q[ERR_W-1] ? AACC_W'(mcand_a) : '0);
				mr_e_q  <= {mr_e_q[ERR_W-2:0], 1'b0};
			end
			ST_SUM: ;
			default: ;
		endcase
	end

endmodule

// ----- sim/tb_pid_with_windup_guard_top.sv -----
// Self-checking testbench of the PID controller with integral clamp.
module tb_pid_with_windup_guard_top;
	import pidwg_pkg::*;

	localparam int FRAC         = 16;
	localparam int SETTLE_CYCLES = 140;   // update latency plus margin
	localparam int HOLD_CYCLES   = 800;
	localparam int STUCK_LIMIT   = 5000;
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_MAX = 32'h8000_0000;

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [1:0]    cfg_idx;
	logic [DW-1:0] cfg_data;

	pidwg_in_if  in_ch();
	pidwg_out_if out_ch();

	pid_with_windup_guard_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// controller settings and state as the block should hold them
	logic signed [31:0] kp = '0;
	logic signed [31:0] ki = '0;
	logic signed [31:0] kd = '0;
	logic [30:0]        wind_lim = '0;
	logic [31:0]        last_time = '0;
	logic signed [31:0] last_meas = '0;
	longint             int_acc = 0;

	logic signed [31:0] drive_q[$];

	bit          gaps_on = 1'b1;
	bit          hold_req = 1'b0;
	int          n_errors = 0;
	int          n_checked = 0;
	int          n_updates = 0;
	int          n_clears = 0;
	int          n_settings = 0;
	int          stuck_cycles = 0;
	logic [31:0] clock_us = '0;
	logic [31:0] setpoint = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Work out the drive value of one item and advance the controller state.
	function automatic bit predict_drive(input cmd_t op, input logic signed [31:0] tgt,
			input logic signed [31:0] meas, input logic [31:0] ts,
			output logic signed [31:0] drv);
		logic [31:0]  dt;
		longint       err, diff, pterm, iterm, dterm, sum, lim;
		logic [63:0]  err_mag, diff_mag, kd_mag, inc;
		logic [127:0] num, den, quo;
		drv = '0;
		if (op == CMD_CLEAR) begin
			int_acc   = 0;
			last_time = ts;
			return 1'b0;
		end
		dt        = ts - last_time;
		last_time = ts;
		err       = longint'(tgt) - longint'(meas);
		err_mag   = (err < 0) ? -err : err;
		inc       = (err_mag * {32'd0, dt}) / 64'd1000000;
		if (err < 0)
			int_acc = int_acc - longint'(inc);
		else
			int_acc = int_acc + longint'(inc);
		lim = longint'({1'b0, wind_lim});
		if (int_acc > lim)
			int_acc = lim;
		if (int_acc < -lim)
			int_acc = -lim;

		diff      = longint'(meas) - longint'(last_meas);
		last_meas = meas;
		dterm     = 0;
		if (dt != 0) begin
			diff_mag = (diff < 0) ? -diff : diff;
			kd_mag   = (kd < 0) ? -longint'(kd) : longint'(kd);
			num      = {64'd0, kd_mag * diff_mag} * 128'd10000;
			den      = {96'd0, dt} << FRAC;
			quo      = num / den;
			// cap the magnitude; the saturated output never sees the difference
			if (quo > (128'd1 << 60))
				quo = 128'd1 << 60;
			dterm = longint'(quo[63:0]);
			if ((kd < 0) != (diff < 0))
				dterm = -dterm;
		end

		pterm = (longint'(kp) * err) >>> FRAC;
		iterm = (longint'(ki) * int_acc) >>> FRAC;
		sum   = pterm + iterm + dterm;
		if (sum > longint'(POS_MAX))
			sum = longint'(POS_MAX);
		if (sum < -longint'(64'h8000_0000))
			sum = -longint'(64'h8000_0000);
		drv = sum[31:0];
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	function automatic logic [31:0] pick_q16();
		int          r;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			case ($urandom_range(0, 4))
				0: v = POS_MAX;
				1: v = NEG_MAX;
				2: v = '0;
				3: v = '1;
				default: v = 32'd1;
			endcase
			return v;
		end
		if (r < 30)
			return $urandom();
		if (r < 65)
			v = $urandom_range(0, 1000 << 16);
		else
			v = $urandom_range(0, 1 << 16);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic logic [31:0] pick_gain();
		int          r;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		if (r < 10)
			return $urandom_range(0, 1) ? POS_MAX : NEG_MAX;
		if (r < 20)
			return $urandom();
		if (r < 70)
			v = $urandom_range(0, 8 << 16);
		else
			v = $urandom_range(0, 1 << 16);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	// bit 31 is sometimes random, to check that the register drops it
	function automatic logic [31:0] pick_limit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return {1'($urandom_range(0, 1)), 31'h7FFF_FFFF};
		if (r < 35)
			return $urandom();
		return $urandom_range(1, 2000 << 16);
	endfunction

	function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
		n_errors++;
		if (n_errors <= 10)
			$display("mismatch %0d: %s, expected %h, got %h", n_errors, what, want, got);
	endfunction

	task automatic send_item(input cmd_t op, input logic [31:0] tgt, input logic [31:0] meas,
			input logic [31:0] ts);
		int                 gap;
		logic signed [31:0] drv;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.cmd      <= op;
		in_ch.target   <= tgt;
		in_ch.measured <= meas;
		in_ch.now_us   <= ts;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		if (op == CMD_CLEAR)
			n_clears++;
		else
			n_updates++;
		if (predict_drive(op, tgt, meas, ts, drv))
			drive_q.push_back(drv);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (drive_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_GAIN_P: kp = val;
			CFG_GAIN_I: ki = val;
			CFG_GAIN_D: kd = val;
			CFG_WINDUP: wind_lim = val[30:0];
		endcase
	endtask

	// Registers change only with the block idle, after all pending results have drained.
	task automatic load_settings(input logic [31:0] p, input logic [31:0] i,
			input logic [31:0] d, input logic [31:0] w);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(CFG_GAIN_P, p);
		write_reg(CFG_GAIN_I, i);
		write_reg(CFG_GAIN_D, d);
		write_reg(CFG_WINDUP, w);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Mostly regular sample times with a measurement near the setpoint.
	task automatic send_random_item();
		int          r;
		logic [31:0] dt_us, meas, off;
		r = $urandom_range(0, 99);
		if (r < 70)
			dt_us = $urandom_range(100, 20000);
		else if (r < 78)
			dt_us = '0;
		else if (r < 88)
			dt_us = $urandom_range(1, 99);
		else if (r < 95)
			dt_us = $urandom_range(20001, 5000000);
		else
			dt_us = $urandom();
		clock_us += dt_us;
		if ($urandom_range(0, 99) < 6) begin
			send_item(CMD_CLEAR, $urandom(), $urandom(), clock_us);
		end else begin
			if ($urandom_range(0, 9) == 0)
				setpoint = pick_q16();
			if ($urandom_range(0, 99) < 80) begin
				off  = $urandom_range(0, 8 << 16);
				meas = setpoint + ($urandom_range(0, 1) ? -off : off);
			end else begin
				meas = pick_q16();
			end
			send_item(CMD_UPDATE, setpoint, meas, clock_us);
		end
	endtask

	task automatic test_reset_values();
		// all gains are zero after reset
		send_item(CMD_UPDATE, 32'h0012_3456, 32'hFFF0_0000, 32'd0);
		send_item(CMD_UPDATE, POS_MAX, NEG_MAX, 32'd1000);
	endtask

	task automatic test_directed();
		load_settings(ONE_Q16, ONE_Q16, ONE_Q16, 100 << 16);
		send_item(CMD_CLEAR, 32'd0, 32'd0, 32'd1000);
		send_item(CMD_UPDATE, 10 << 16, 32'd0, 32'd1000);         // zero elapsed time
		send_item(CMD_UPDATE, 10 << 16, 2 << 16, 32'd501000);
		send_item(CMD_UPDATE, POS_MAX, NEG_MAX, 32'hF000_0000);   // clamp high, saturate
		send_item(CMD_UPDATE, NEG_MAX, POS_MAX, 32'hF000_1000);   // clamp low, saturate
		send_item(CMD_CLEAR, 32'd5, 32'd7, 32'hFFFF_FF00);
		send_item(CMD_UPDATE, 3 << 16, 1 << 16, 32'h0000_0100);   // timestamp wrap
		send_item(CMD_UPDATE, 3 << 16, 1 << 16, 32'h0000_00FF);   // longest interval

		// extreme gains; windup data carries bit 31, which the register drops
		load_settings(NEG_MAX, POS_MAX, NEG_MAX, 32'hFFFF_FFFF);
		send_item(CMD_UPDATE, POS_MAX, NEG_MAX, 32'h0000_0100);
		send_item(CMD_UPDATE, NEG_MAX, POS_MAX, 32'h0000_0101);   // full-scale jump in 1 us
		send_item(CMD_UPDATE, 32'd0, NEG_MAX, 32'h0000_0101);
		send_item(CMD_UPDATE, 32'd0, 32'd0, 32'h8000_0101);

		load_settings(POS_MAX, NEG_MAX, POS_MAX, 32'd0);           // no room for the integral
		send_item(CMD_UPDATE, POS_MAX, NEG_MAX, 32'h8001_0101);
		send_item(CMD_UPDATE, NEG_MAX, POS_MAX, 32'h8001_0102);
		send_item(CMD_UPDATE, 32'hFFFF_FFFF, 32'd1, 32'h8001_0202);
		clock_us = 32'h8001_0202;
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 6; ph++) begin
			gaps_on = (ph != 2);
			load_settings(pick_gain(), pick_gain(), pick_gain(), pick_limit());
			repeat (280) send_random_item();
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_backpressure();
		load_settings(ONE_Q16, ONE_Q16 >> 2, ONE_Q16 >> 4, 500 << 16);
		gaps_on  = 1'b0;
		hold_req = 1'b1;
		repeat (12) send_random_item();
		wait_drained();
		gaps_on = 1'b1;
		repeat (60) send_random_item();
		wait_drained();
	endtask

	initial begin
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_idx        <= CFG_GAIN_P;
		cfg_data       <= '0;
		in_ch.valid    <= 1'b0;
		in_ch.cmd      <= CMD_UPDATE;
		in_ch.target   <= '0;
		in_ch.measured <= '0;
		in_ch.now_us   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed();
		test_random_phases();
		test_backpressure();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d updates and %0d clears over %0d gain settings;",
			n_updates, n_clears, n_settings);
		$display("checked %0d drive values, %0d mismatches.", n_checked, n_errors);
		if (n_errors == 0 && drive_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				stall_left = HOLD_CYCLES;
				hold_req   = 1'b0;
			end else if (stall_left == 0 && gaps_on && $urandom_range(0, 99) < 20) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		logic signed [31:0] want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (drive_q.size() == 0) begin
				flag_mismatch("drive with no update pending", 'x, out_ch.drive);
			end else begin
				want = drive_q.pop_front();
				n_checked++;
				if (out_ch.drive !== want)
					flag_mismatch("drive", want, out_ch.drive);
			end
		end
	end

	// end the run if no transfer happens for too long
	always @(posedge clk) begin
		if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
				(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("no transfer for %0d cycles", STUCK_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule

// ----- filelist.f -----
design/pidwg_pkg.sv
design/pidwg_in_if.sv
design/pidwg_out_if.sv
design/pid_with_windup_guard_top.sv
sim/tb_pid_with_windup_guard_top.sv
